>>> rtl/tile_map_scroll_renderer_assert.svh
// Assertion macros shared by the RTL.
`ifndef TILE_MAP_SCROLL_RENDERER_ASSERT_SVH
`define TILE_MAP_SCROLL_RENDERER_ASSERT_SVH

// Same-cycle implication.
`define TMSR_ASSERT_NOW(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("tmsr: same-cycle check failed");

// Next-cycle implication.
`define TMSR_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("tmsr: next-cycle check failed");

`endif

>>> rtl/tmsr_pkg.sv
`default_nettype none

package tmsr_pkg;

    localparam int MAX_CELLS   = 4096;
    localparam int MAX_LAYERS  = 4;
    localparam int MAX_COLS    = 64;
    localparam int STORE_DEPTH = MAX_LAYERS * MAX_CELLS;

    // Field and register widths
    localparam int CELL_W     = 12;
    localparam int LAYER_W    = 2;
    localparam int FRAME_W    = 16;
    localparam int SCROLL_W   = 16;
    localparam int POS_W      = 15;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int COLS_W     = 7;
    localparam int TILE_W     = 9;
    localparam int SCR_W      = 12;
    localparam int LAYERS_W   = 3;
    localparam int ROW_W      = 6;
    localparam int TIDX_W     = 6;
    localparam int OFF_W      = 8;
    localparam int PIX_W      = 14;
    localparam int MAPPX_W    = 15;
    localparam int HV_W       = 14;
    localparam int TROW_W     = 7;

    localparam int MAP_MAX    = 64;
    localparam int TILE_MAX   = 256;

    // Divider
    localparam int DIV_NW     = 16;
    localparam int DIV_DW     = 9;
    localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

    // Request codes
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_SCROLL = 2'd1;
    localparam logic [1:0] REQ_ROW    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_H      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM_X,
        ST_LIM_Y,
        ST_CLAMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CLIP,
        ST_ROW,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_H,
        DIV_V,
        DIV_X,
        DIV_Y
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     store_we;
        logic     lim_x;
        logic     lim_y;
        logic     clamp;
        logic     scroll_upd;
        logic     div_start;
        logic     div_cap;
        div_sel_t div_sel;
        logic     clip;
        logic     row_setup;
        logic     issue;
    } cmd_t;

    typedef struct packed {
        logic frame_start;
        logic div_done;
        logic slot_free;
        logic col_last;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/tmsr_ram.sv
`default_nettype none

module tmsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/tmsr_div.sv
`default_nettype none

module tmsr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tmsr_pkg::DIV_NW-1:0]  dividend,
    input  logic [tmsr_pkg::DIV_DW-1:0]  divisor,
    output logic                         done,
    output logic [tmsr_pkg::DIV_NW-1:0]  quotient,
    output logic [tmsr_pkg::DIV_DW-1:0]  remainder
);

    import tmsr_pkg::*;

    logic [DIV_NW-1:0]    quo_reg, quo_next;
    logic [DIV_DW-1:0]    rem_reg, rem_next;
    logic [DIV_DW-1:0]    den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [DIV_DW:0]      trial;
    logic [DIV_DW:0]      diff;
    logic                 ge;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_NW);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[DIV_NW-2:0], ge};
            rem_next  = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/tmsr_ctrl.sv
`default_nettype none

module tmsr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       req_type,
    output logic             in_stall,
    input  tmsr_pkg::stat_t  stat,
    output tmsr_pkg::cmd_t   cmd
);

    import tmsr_pkg::*;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic     is_row_reg, is_row_next;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        is_row_next = is_row_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_SCROLL:
                        begin
                            state_next  = ST_LIM_X;
                            is_row_next = 1'b0;
                        end
                        REQ_ROW:
                        begin
                            if (stat.frame_start)
                            begin
                                state_next  = ST_LIM_X;
                                is_row_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ROW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LIM_X:
            begin
                state_next = ST_LIM_Y;
            end
            ST_LIM_Y:
            begin
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (is_row_reg)
                begin
                    state_next = ST_DIV_GO;
                    sel_next   = DIV_H;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    case (sel_reg)
                        DIV_H:
                        begin
                            sel_next   = DIV_V;
                            state_next = ST_DIV_GO;
                        end
                        DIV_V:
                        begin
                            sel_next   = DIV_X;
                            state_next = ST_DIV_GO;
                        end
                        DIV_X:
                        begin
                            sel_next   = DIV_Y;
                            state_next = ST_DIV_GO;
                        end
                        default:
                        begin
                            state_next = ST_CLIP;
                        end
                    endcase
                end
            end
            ST_CLIP:
            begin
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.slot_free && stat.col_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        in_stall    = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.accept   = in_valid;
                cmd.store_we = in_valid && (req_type == REQ_WRITE);
            end
            ST_LIM_X:
            begin
                cmd.lim_x = 1'b1;
            end
            ST_LIM_Y:
            begin
                cmd.lim_y = 1'b1;
            end
            ST_CLAMP:
            begin
                cmd.clamp      = 1'b1;
                cmd.scroll_upd = !is_row_reg;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                cmd.div_cap = stat.div_done;
            end
            ST_CLIP:
            begin
                cmd.clip = 1'b1;
            end
            ST_ROW:
            begin
                cmd.row_setup = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.issue = stat.slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sel_reg    <= DIV_H;
            is_row_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            is_row_reg <= is_row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tmsr_dp.sv
`default_nettype none

module tmsr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmsr_pkg::cmd_t                    cmd,
    output tmsr_pkg::stat_t                   stat,
    input  logic                              cfg_we,
    input  logic [tmsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmsr_pkg::CFG_W-1:0]        cfg_data,
    input  logic [tmsr_pkg::SCROLL_W-1:0]     scroll_x,
    input  logic [tmsr_pkg::SCROLL_W-1:0]     scroll_y,
    input  logic [tmsr_pkg::LAYER_W-1:0]      layer_sel,
    input  logic [tmsr_pkg::CELL_W-1:0]       cell_index,
    input  logic [tmsr_pkg::FRAME_W-1:0]      frame_value,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [tmsr_pkg::FRAME_W-1:0]      sprite_frame,
    output logic signed [tmsr_pkg::POS_W-1:0] pos_x,
    output logic signed [tmsr_pkg::POS_W-1:0] pos_y,
    output logic [tmsr_pkg::LAYER_W-1:0]      layer_out,
    output logic                              row_last,
    output logic                              frame_last
);

    import tmsr_pkg::*;

    // Configuration, held already clamped to its legal range
    logic [COLS_W-1:0]   cols_reg, cols_next, rows_reg, rows_next;
    logic [TILE_W-1:0]   tw_reg, tw_next, th_reg, th_next;
    logic [SCR_W-1:0]    sw_reg, sw_next, sh_reg, sh_next;
    logic [LAYERS_W-1:0] layers_reg, layers_next;

    // Scroll and cursor
    logic [PIX_W-1:0]    scroll_x_reg, scroll_x_next, scroll_y_reg, scroll_y_next;
    logic [LAYER_W-1:0]  cursor_layer_reg, cursor_layer_next;
    logic [ROW_W-1:0]    cursor_row_reg, cursor_row_next;

    // Request scratch and frame setup
    logic [SCROLL_W-1:0] req_sx_reg, req_sx_next, req_sy_reg, req_sy_next;
    logic [PIX_W-1:0]    lim_x_reg, lim_x_next, lim_y_reg, lim_y_next;
    logic [PIX_W-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic [SCR_W-1:0]    hq_reg, hq_next, vq_reg, vq_next;
    logic [TIDX_W-1:0]   stx_reg, stx_next, sty_reg, sty_next;
    logic [OFF_W-1:0]    offx_reg, offx_next, offy_reg, offy_next;
    logic [COLS_W-1:0]   hcount_reg, hcount_next, vcount_reg, vcount_next;
    logic [TILE_W-1:0]   ftw_reg, ftw_next, fth_reg, fth_next;
    logic [COLS_W-1:0]   fcols_reg, fcols_next;
    logic [LAYERS_W-1:0] flayers_reg, flayers_next;

    // Row walk
    logic [CELL_W-1:0]        idx_reg, idx_next;
    logic [COLS_W-1:0]        col_reg, col_next;
    logic signed [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic                     last_frame_reg, last_frame_next;

    // Read stage and output register
    logic                     s1_v_reg, s1_v_next;
    logic signed [POS_W-1:0]  s1_px_reg, s1_px_next, s1_py_reg, s1_py_next;
    logic [LAYER_W-1:0]       s1_layer_reg, s1_layer_next;
    logic                     s1_rlast_reg, s1_rlast_next, s1_flast_reg, s1_flast_next;
    logic                     out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]       frame_out_reg, frame_out_next;
    logic signed [POS_W-1:0]  px_out_reg, px_out_next, py_out_reg, py_out_next;
    logic [LAYER_W-1:0]       layer_out_reg, layer_out_next;
    logic                     rlast_out_reg, rlast_out_next, flast_out_reg, flast_out_next;

    // Combinational helpers
    logic [COLS_W-1:0]   mul_tiles;
    logic [TILE_W-1:0]   mul_size;
    logic [SCR_W-1:0]    mul_scr;
    logic [MAPPX_W-1:0]  map_px;
    logic [PIX_W-1:0]    lim_val;
    logic [SCROLL_W-1:0] src_x, src_y;
    logic [PIX_W-1:0]    cx, cy;
    logic [DIV_NW-1:0]   div_a;
    logic [DIV_DW-1:0]   div_b;
    logic                div_done;
    logic [DIV_NW-1:0]   div_q;
    logic [DIV_DW-1:0]   div_r;
    logic [HV_W-1:0]     h_full, h_clip, h_lim, v_full, v_clip;
    logic [TROW_W-1:0]   tile_row;
    logic [HV_W-1:0]     row_base;
    logic [POS_W-1:0]    py_prod;
    logic [COLS_W-1:0]   row_inc;
    logic [LAYERS_W-1:0] layer_inc;
    logic                col_last;
    logic                adv_out;
    logic [FRAME_W-1:0]  ram_rdata;

    tmsr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store_we),
        .waddr ({layer_sel, cell_index}),
        .wdata (frame_value),
        .re    (cmd.issue),
        .raddr ({cursor_layer_reg, idx_reg}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (cmd.div_sel)
            DIV_V:
            begin
                div_a = DIV_NW'(sh_reg);
                div_b = th_reg;
            end
            DIV_X:
            begin
                div_a = DIV_NW'(sx_reg);
                div_b = tw_reg;
            end
            DIV_Y:
            begin
                div_a = DIV_NW'(sy_reg);
                div_b = th_reg;
            end
            default:
            begin
                div_a = DIV_NW'(sw_reg);
                div_b = tw_reg;
            end
        endcase
    end

    tmsr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        // Scroll limit: map size in pixels less screen size, floored at zero
        mul_tiles = cmd.lim_y ? rows_reg : cols_reg;
        mul_size  = cmd.lim_y ? th_reg : tw_reg;
        mul_scr   = cmd.lim_y ? sh_reg : sw_reg;
        map_px    = MAPPX_W'(mul_tiles) * MAPPX_W'(mul_size);
        lim_val   = (map_px > MAPPX_W'(mul_scr)) ? PIX_W'(map_px - MAPPX_W'(mul_scr)) : '0;

        src_x = cmd.scroll_upd ? req_sx_reg : SCROLL_W'(scroll_x_reg);
        src_y = cmd.scroll_upd ? req_sy_reg : SCROLL_W'(scroll_y_reg);
        cx    = (src_x > SCROLL_W'(lim_x_reg)) ? lim_x_reg : src_x[PIX_W-1:0];
        cy    = (src_y > SCROLL_W'(lim_y_reg)) ? lim_y_reg : src_y[PIX_W-1:0];

        // Visible tile counts, cut at the map edge
        h_full = HV_W'(hq_reg) + HV_W'(2);
        h_clip = ((h_full + HV_W'(stx_reg)) > HV_W'(cols_reg)) ?
                 (HV_W'(cols_reg) - HV_W'(stx_reg)) : h_full;
        h_lim  = (h_clip > HV_W'(MAX_COLS)) ? HV_W'(MAX_COLS) : h_clip;
        v_full = HV_W'(vq_reg) + HV_W'(2);
        v_clip = ((v_full + HV_W'(sty_reg)) > HV_W'(rows_reg)) ?
                 (HV_W'(rows_reg) - HV_W'(sty_reg)) : v_full;

        tile_row = TROW_W'(sty_reg) + TROW_W'(cursor_row_reg);
        row_base = HV_W'(tile_row) * HV_W'(fcols_reg) + HV_W'(stx_reg);
        py_prod  = POS_W'(cursor_row_reg) * POS_W'(fth_reg);

        row_inc   = COLS_W'(cursor_row_reg) + COLS_W'(1);
        layer_inc = LAYERS_W'(cursor_layer_reg) + LAYERS_W'(1);
        col_last  = ((col_reg + COLS_W'(1)) == hcount_reg);
        adv_out   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        tw_next     = tw_reg;
        th_next     = th_reg;
        sw_next     = sw_reg;
        sh_next     = sh_reg;
        layers_next = layers_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_COLS:
                begin
                    cols_next = (cfg_data[COLS_W-1:0] == '0) ? COLS_W'(1) :
                                (cfg_data[COLS_W-1:0] > COLS_W'(MAP_MAX)) ? COLS_W'(MAP_MAX) :
                                cfg_data[COLS_W-1:0];
                end
                CFG_MAP_ROWS:
                begin
                    rows_next = (cfg_data[COLS_W-1:0] == '0) ? COLS_W'(1) :
                                (cfg_data[COLS_W-1:0] > COLS_W'(MAP_MAX)) ? COLS_W'(MAP_MAX) :
                                cfg_data[COLS_W-1:0];
                end
                CFG_TILE_W:
                begin
                    tw_next = (cfg_data[TILE_W-1:0] == '0) ? TILE_W'(1) :
                              (cfg_data[TILE_W-1:0] > TILE_W'(TILE_MAX)) ? TILE_W'(TILE_MAX) :
                              cfg_data[TILE_W-1:0];
                end
                CFG_TILE_H:
                begin
                    th_next = (cfg_data[TILE_W-1:0] == '0) ? TILE_W'(1) :
                              (cfg_data[TILE_W-1:0] > TILE_W'(TILE_MAX)) ? TILE_W'(TILE_MAX) :
                              cfg_data[TILE_W-1:0];
                end
                CFG_SCREEN_W:
                begin
                    sw_next = (cfg_data[SCR_W-1:0] == '0) ? SCR_W'(1) : cfg_data[SCR_W-1:0];
                end
                CFG_SCREEN_H:
                begin
                    sh_next = (cfg_data[SCR_W-1:0] == '0) ? SCR_W'(1) : cfg_data[SCR_W-1:0];
                end
                CFG_LAYER_COUNT:
                begin
                    layers_next = (cfg_data[LAYERS_W-1:0] == '0) ? LAYERS_W'(1) :
                                  (cfg_data[LAYERS_W-1:0] > LAYERS_W'(MAX_LAYERS)) ?
                                  LAYERS_W'(MAX_LAYERS) : cfg_data[LAYERS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        scroll_x_next     = scroll_x_reg;
        scroll_y_next     = scroll_y_reg;
        cursor_layer_next = cursor_layer_reg;
        cursor_row_next   = cursor_row_reg;
        req_sx_next       = req_sx_reg;
        req_sy_next       = req_sy_reg;
        lim_x_next        = lim_x_reg;
        lim_y_next        = lim_y_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        hq_next           = hq_reg;
        vq_next           = vq_reg;
        stx_next          = stx_reg;
        sty_next          = sty_reg;
        offx_next         = offx_reg;
        offy_next         = offy_reg;
        hcount_next       = hcount_reg;
        vcount_next       = vcount_reg;
        ftw_next          = ftw_reg;
        fth_next          = fth_reg;
        fcols_next        = fcols_reg;
        flayers_next      = flayers_reg;
        idx_next          = idx_reg;
        col_next          = col_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        last_frame_next   = last_frame_reg;
        s1_px_next        = s1_px_reg;
        s1_py_next        = s1_py_reg;
        s1_layer_next     = s1_layer_reg;
        s1_rlast_next     = s1_rlast_reg;
        s1_flast_next     = s1_flast_reg;

        if (cmd.accept)
        begin
            req_sx_next = scroll_x;
            req_sy_next = scroll_y;
        end

        if (cmd.lim_x)
        begin
            lim_x_next = lim_val;
        end
        if (cmd.lim_y)
        begin
            lim_y_next = lim_val;
        end

        if (cmd.clamp)
        begin
            sx_next = cx;
            sy_next = cy;
            if (cmd.scroll_upd)
            begin
                scroll_x_next = cx;
                scroll_y_next = cy;
            end
        end

        if (cmd.div_cap)
        begin
            case (cmd.div_sel)
                DIV_V:
                begin
                    vq_next = div_q[SCR_W-1:0];
                end
                DIV_X:
                begin
                    stx_next  = div_q[TIDX_W-1:0];
                    offx_next = div_r[OFF_W-1:0];
                end
                DIV_Y:
                begin
                    sty_next  = div_q[TIDX_W-1:0];
                    offy_next = div_r[OFF_W-1:0];
                end
                default:
                begin
                    hq_next = div_q[SCR_W-1:0];
                end
            endcase
        end

        if (cmd.clip)
        begin
            hcount_next  = h_lim[COLS_W-1:0];
            vcount_next  = v_clip[COLS_W-1:0];
            ftw_next     = tw_reg;
            fth_next     = th_reg;
            fcols_next   = cols_reg;
            flayers_next = layers_reg;
        end

        if (cmd.row_setup)
        begin
            idx_next        = row_base[CELL_W-1:0];
            col_next        = '0;
            px_next         = $signed(POS_W'(0)) - $signed(POS_W'(offx_reg));
            py_next         = $signed(py_prod) - $signed(POS_W'(offy_reg));
            last_frame_next = (row_inc >= vcount_reg) && (layer_inc >= flayers_reg);
        end
        else if (cmd.issue)
        begin
            idx_next      = idx_reg + CELL_W'(1);
            col_next      = col_reg + COLS_W'(1);
            px_next       = px_reg + $signed(POS_W'(ftw_reg));
            s1_px_next    = px_reg;
            s1_py_next    = py_reg;
            s1_layer_next = cursor_layer_reg;
            s1_rlast_next = col_last;
            s1_flast_next = col_last && last_frame_reg;

            // Row done: step the cursor to the next row or layer
            if (col_last)
            begin
                if (row_inc >= vcount_reg)
                begin
                    cursor_row_next   = '0;
                    cursor_layer_next = (layer_inc >= flayers_reg) ? '0 :
                                        layer_inc[LAYER_W-1:0];
                end
                else
                begin
                    cursor_row_next = row_inc[ROW_W-1:0];
                end
            end
        end
    end

    // Read stage feeds the output register; the RAM read data holds while stage 1 waits
    always_comb
    begin
        s1_v_next      = s1_v_reg;
        out_valid_next = out_valid_reg;
        frame_out_next = frame_out_reg;
        px_out_next    = px_out_reg;
        py_out_next    = py_out_reg;
        layer_out_next = layer_out_reg;
        rlast_out_next = rlast_out_reg;
        flast_out_next = flast_out_reg;

        if (adv_out)
        begin
            out_valid_next = s1_v_reg;
            if (s1_v_reg)
            begin
                frame_out_next = ram_rdata;
                px_out_next    = s1_px_reg;
                py_out_next    = s1_py_reg;
                layer_out_next = s1_layer_reg;
                rlast_out_next = s1_rlast_reg;
                flast_out_next = s1_flast_reg;
            end
        end

        if (cmd.issue)
        begin
            s1_v_next = 1'b1;
        end
        else if (adv_out)
        begin
            s1_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg         <= COLS_W'(MAP_MAX);
            rows_reg         <= COLS_W'(MAP_MAX);
            tw_reg           <= TILE_W'(16);
            th_reg           <= TILE_W'(16);
            sw_reg           <= SCR_W'(320);
            sh_reg           <= SCR_W'(240);
            layers_reg       <= LAYERS_W'(1);
            scroll_x_reg     <= '0;
            scroll_y_reg     <= '0;
            cursor_layer_reg <= '0;
            cursor_row_reg   <= '0;
            s1_v_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cols_reg         <= cols_next;
            rows_reg         <= rows_next;
            tw_reg           <= tw_next;
            th_reg           <= th_next;
            sw_reg           <= sw_next;
            sh_reg           <= sh_next;
            layers_reg       <= layers_next;
            scroll_x_reg     <= scroll_x_next;
            scroll_y_reg     <= scroll_y_next;
            cursor_layer_reg <= cursor_layer_next;
            cursor_row_reg   <= cursor_row_next;
            s1_v_reg         <= s1_v_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_sx_reg     <= req_sx_next;
        req_sy_reg     <= req_sy_next;
        lim_x_reg      <= lim_x_next;
        lim_y_reg      <= lim_y_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        hq_reg         <= hq_next;
        vq_reg         <= vq_next;
        stx_reg        <= stx_next;
        sty_reg        <= sty_next;
        offx_reg       <= offx_next;
        offy_reg       <= offy_next;
        hcount_reg     <= hcount_next;
        vcount_reg     <= vcount_next;
        ftw_reg        <= ftw_next;
        fth_reg        <= fth_next;
        fcols_reg      <= fcols_next;
        flayers_reg    <= flayers_next;
        idx_reg        <= idx_next;
        col_reg        <= col_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        last_frame_reg <= last_frame_next;
        s1_px_reg      <= s1_px_next;
        s1_py_reg      <= s1_py_next;
        s1_layer_reg   <= s1_layer_next;
        s1_rlast_reg   <= s1_rlast_next;
        s1_flast_reg   <= s1_flast_next;
        frame_out_reg  <= frame_out_next;
        px_out_reg     <= px_out_next;
        py_out_reg     <= py_out_next;
        layer_out_reg  <= layer_out_next;
        rlast_out_reg  <= rlast_out_next;
        flast_out_reg  <= flast_out_next;
    end

    assign stat.frame_start = (cursor_layer_reg == '0) && (cursor_row_reg == '0);
    assign stat.div_done    = div_done;
    assign stat.slot_free   = !s1_v_reg || adv_out;
    assign stat.col_last    = col_last;

    assign out_valid    = out_valid_reg;
    assign sprite_frame = frame_out_reg;
    assign pos_x        = px_out_reg;
    assign pos_y        = py_out_reg;
    assign layer_out    = layer_out_reg;
    assign row_last     = rlast_out_reg;
    assign frame_last   = flast_out_reg;

endmodule

`default_nettype wire

>>> rtl/tile_map_scroll_renderer.sv
// Tile-map background renderer. Requests on the input channel write one tile word, set the
// scroll position (clamped to the map against the current geometry), or emit the next row of
// draw commands. A row request sets up the row, then sends its draw commands at one per cycle
// while the output does not stall, through a RAM read stage and an output register; the
// first row of each frame first runs the scroll clamp (x limit, y limit, clamp), then four
// restoring divisions (start tile, pixel offset and visible counts) done in turn on one
// shared divider, and then a clip of the tile counts. Output stalls stretch a row.
// Geometry and scroll writes take effect at the next frame start. The tile
// store is a 16K x 16 RAM with no reset; reading a cell never written gives an arbitrary
// frame number.
`default_nettype none
`include "tile_map_scroll_renderer_assert.svh"

module tile_map_scroll_renderer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tmsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmsr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [tmsr_pkg::SCROLL_W-1:0]     scroll_x,
    input  logic [tmsr_pkg::SCROLL_W-1:0]     scroll_y,
    input  logic [tmsr_pkg::LAYER_W-1:0]      layer_sel,
    input  logic [tmsr_pkg::CELL_W-1:0]       cell_index,
    input  logic [tmsr_pkg::FRAME_W-1:0]      frame_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tmsr_pkg::FRAME_W-1:0]      sprite_frame,
    output logic signed [tmsr_pkg::POS_W-1:0] pos_x,
    output logic signed [tmsr_pkg::POS_W-1:0] pos_y,
    output logic [tmsr_pkg::LAYER_W-1:0]      layer_out,
    output logic                              row_last,
    output logic                              frame_last
);

    import tmsr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tmsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmsr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .scroll_x     (scroll_x),
        .scroll_y     (scroll_y),
        .layer_sel    (layer_sel),
        .cell_index   (cell_index),
        .frame_value  (frame_value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .sprite_frame (sprite_frame),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .layer_out    (layer_out),
        .row_last     (row_last),
        .frame_last   (frame_last)
    );

    // Tile reads happen only while a row request is in progress
    `TMSR_ASSERT_NOW(a_issue_while_busy, clk, rst_n, cmd.issue, in_stall)
    // Issuing the last tile of a row frees the input side
    `TMSR_ASSERT_NEXT(a_row_end_frees, clk, rst_n, cmd.issue && stat.col_last, !in_stall)
    // A set-scroll request always runs through the clamp sequence
    `TMSR_ASSERT_NEXT(a_scroll_busy, clk, rst_n, in_valid && !in_stall && (req_type == REQ_SCROLL), in_stall)

endmodule

`default_nettype wire
